// ===== sv/tmpr_pkg.sv =====
`timescale 1ns / 1ps
package tmpr_pkg;

	// Default geometry
	localparam int MAP_COLUMNS_DEF     = 64;
	localparam int MAP_ROWS_DEF        = 64;
	localparam int TILE_PX_W_DEF       = 16;
	localparam int TILE_PX_H_DEF       = 16;
	localparam int MAX_TILES_DEF       = 16;
	localparam int PALETTE_ENTRIES_DEF = 16;

	// Store shapes
	localparam int MAP_DEPTH   = 4096;
	localparam int MAP_DW      = 8;
	localparam int PIX_DEPTH   = 4096;
	localparam int PIX_DW      = 4;
	localparam int PAL_DEPTH   = 256;
	localparam int PAL_DW      = 16;
	localparam int TRN_DEPTH   = 16;
	localparam int TRN_DW      = 17;

	// Field widths
	localparam int KIND_W  = 3;
	localparam int SLOT_W  = 12;
	localparam int VALUE_W = 17;
	localparam int COORD_W = 12;
	localparam int COLOR_W = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_MAP      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TILE_PIX = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PALETTE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TRANSP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RENDER   = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 4'd7;

	// One rendered pixel
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               write;
	} pix_t;

endpackage

// ===== sv/tmpr_ram.sv =====
`timescale 1ns / 1ps
// Single-port RAM, registered read; read data holds while en is low
module tmpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== sv/tmpr_cdiv.sv =====
`timescale 1ns / 1ps
// Two-stage divide by a constant: reciprocal multiply, then one
// compare-and-subtract correction. Both stages advance only while en is high.
module tmpr_cdiv #(
	parameter int DIVISOR = 16,
	parameter int IN_W    = 13,
	parameter int REM_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [IN_W-1:0]  dividend,
	output logic [IN_W-1:0]  quot,
	output logic [REM_W-1:0] rem
);

	// Estimate is the true quotient or one below it
	localparam int K  = IN_W + 1;
	localparam int MW = K + 1;
	localparam logic [MW-1:0]   RECIP = MW'((1 << K) / DIVISOR);
	localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

	logic [IN_W+MW-1:0] prod;
	logic [IN_W-1:0]    q0_s2;
	logic [IN_W-1:0]    x_s2;
	logic [2*IN_W-1:0]  back;
	logic [IN_W-1:0]    r0;
	logic [IN_W-1:0]    r_adj;
	logic               fix;
	logic [IN_W-1:0]    quot_s3;
	logic [REM_W-1:0]   rem_s3;

	// Stage 2: reciprocal estimate
	assign prod = dividend * RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s2 <= prod[K +: IN_W];
			x_s2  <= dividend;
		end
	end

	// Stage 3: remainder and correction
	assign back  = q0_s2 * DIV_C;
	assign r0    = x_s2 - back[IN_W-1:0];
	assign fix   = (r0 >= DIV_C);
	assign r_adj = fix ? (r0 - DIV_C) : r0;

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s3 <= fix ? (q0_s2 + IN_W'(1)) : q0_s2;
			rem_s3  <= r_adj[REM_W-1:0];
		end
	end

	assign quot = quot_s3;
	assign rem  = rem_s3;

endmodule

// ===== sv/tmpr_out.sv =====
`timescale 1ns / 1ps
// Output register with a skid stage; ready drops only while the skid holds an item
module tmpr_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  tmpr_pkg::pix_t                     push_data,
	output logic                               ready,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tmpr_pkg::COLOR_W-1:0]       m_tdata,  // pixel_color
	output logic                               m_tuser   // pixel_write
);

	logic           out_valid_q;
	logic           skid_valid_q;
	tmpr_pkg::pix_t out_data_q;
	tmpr_pkg::pix_t skid_data_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || m_tready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || m_tready) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

	assign ready    = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q.color;
	assign m_tuser  = out_data_q.write;

`ifndef SYNTHESIS
	// skid only fills behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item with output empty");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready && push))
		else $error("skid filled without a stalled output");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("unwritten pixel carries a color");
`endif

endmodule

// ===== sv/tile_map_pixel_renderer.sv =====
`timescale 1ns / 1ps
// The result shows on m_tvalid after seven pipeline stages, the first loaded at the input
// accept edge, and then the output register; one item per cycle sustained while the
// output skid is not full.
// The rate is set by the chain of four single-port stores, each used at most once per item
// in a fixed stage (map, tile pixel and transparent, palette), in item order.
// Reset clears valid bits and loads register defaults; stores are not cleared.
module tile_map_pixel_renderer #(
	parameter int MAP_COLUMNS     = tmpr_pkg::MAP_COLUMNS_DEF,
	parameter int MAP_ROWS        = tmpr_pkg::MAP_ROWS_DEF,
	parameter int TILE_PX_W       = tmpr_pkg::TILE_PX_W_DEF,
	parameter int TILE_PX_H       = tmpr_pkg::TILE_PX_H_DEF,
	parameter int MAX_TILES       = tmpr_pkg::MAX_TILES_DEF,
	parameter int PALETTE_ENTRIES = tmpr_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [55:0]                         s_tdata,  // slot, value, screen_x, screen_y
	input  logic [tmpr_pkg::KIND_W-1:0]         s_tuser,  // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tmpr_pkg::COLOR_W-1:0]        m_tdata,  // pixel_color
	output logic                                m_tuser,  // pixel_write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tmpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int MC_W = tmpr_pkg::COORD_W + 1;
	localparam int RXW  = (TILE_PX_W > 1) ? $clog2(TILE_PX_W) : 1;
	localparam int RYW  = (TILE_PX_H > 1) ? $clog2(TILE_PX_H) : 1;
	localparam logic [MC_W:0]  MAPC_LIM = (MC_W + 1)'(MAP_COLUMNS);
	localparam logic [MC_W:0]  MAPR_LIM = (MC_W + 1)'(MAP_ROWS);
	localparam logic [8:0]     MAPC_C   = 9'(MAP_COLUMNS);
	localparam logic [8:0]     MAXT_C   = 9'(MAX_TILES);
	localparam logic [21:0]    TPIX_C   = 22'(TILE_PX_W * TILE_PX_H);
	localparam logic [21:0]    TW_C     = 22'(TILE_PX_W);
	localparam logic [16:0]    PE_C     = 17'(PALETTE_ENTRIES);

	// Configuration registers
	logic [11:0] cfg_window_x_q;
	logic [11:0] cfg_window_y_q;
	logic [12:0] cfg_window_w_q;
	logic [12:0] cfg_window_h_q;
	logic [11:0] cfg_scroll_x_q;
	logic [11:0] cfg_scroll_y_q;
	logic [4:0]  cfg_tile_count_q;
	logic [16:0] cfg_background_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_window_x_q   <= '0;
			cfg_window_y_q   <= '0;
			cfg_window_w_q   <= 13'd320;
			cfg_window_h_q   <= 13'd240;
			cfg_scroll_x_q   <= '0;
			cfg_scroll_y_q   <= '0;
			cfg_tile_count_q <= 5'd16;
			cfg_background_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				tmpr_pkg::CFG_WINDOW_X:      cfg_window_x_q   <= cfg_data[11:0];
				tmpr_pkg::CFG_WINDOW_Y:      cfg_window_y_q   <= cfg_data[11:0];
				tmpr_pkg::CFG_WINDOW_WIDTH:  cfg_window_w_q   <= cfg_data[12:0];
				tmpr_pkg::CFG_WINDOW_HEIGHT: cfg_window_h_q   <= cfg_data[12:0];
				tmpr_pkg::CFG_SCROLL_X:      cfg_scroll_x_q   <= cfg_data[11:0];
				tmpr_pkg::CFG_SCROLL_Y:      cfg_scroll_y_q   <= cfg_data[11:0];
				tmpr_pkg::CFG_TILE_COUNT:    cfg_tile_count_q <= cfg_data[4:0];
				tmpr_pkg::CFG_BACKGROUND:    cfg_background_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance: the whole pipe moves unless the output skid is full
	logic pipe_en;
	logic out_ready;
	assign pipe_en  = out_ready;
	assign s_tready = pipe_en;

	// Input unpack
	logic [11:0] in_slot;
	logic [16:0] in_value;
	logic [11:0] in_sx;
	logic [11:0] in_sy;
	assign in_slot  = s_tdata[11:0];
	assign in_value = s_tdata[28:12];
	assign in_sx    = s_tdata[40:29];
	assign in_sy    = s_tdata[52:41];

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: window test and map coordinates
	logic [13:0]     win_xe, win_ye;
	logic            in_win;
	logic [MC_W-1:0] mx_n, my_n;
	logic [11:0]     off_x, off_y;

	assign win_xe = {2'b0, cfg_window_x_q} + {1'b0, cfg_window_w_q};
	assign win_ye = {2'b0, cfg_window_y_q} + {1'b0, cfg_window_h_q};
	assign in_win = (in_sx >= cfg_window_x_q) && ({2'b0, in_sx} < win_xe) &&
	                (in_sy >= cfg_window_y_q) && ({2'b0, in_sy} < win_ye);
	assign off_x  = in_sx - cfg_window_x_q;
	assign off_y  = in_sy - cfg_window_y_q;
	assign mx_n   = {1'b0, cfg_scroll_x_q} + {1'b0, off_x};
	assign my_n   = {1'b0, cfg_scroll_y_q} + {1'b0, off_y};

	logic [2:0]      kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6, kind_s7;
	logic [11:0]     slot_s1, slot_s2, slot_s3, slot_s4, slot_s5, slot_s6;
	logic [16:0]     value_s1, value_s2, value_s3, value_s4, value_s5, value_s6;
	logic            inwin_s1, inwin_s2, inwin_s3, inwin_s4, inwin_s5, inwin_s6, inwin_s7;
	logic [MC_W-1:0] mx_s1, my_s1;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			kind_s1  <= s_tuser;
			slot_s1  <= in_slot;
			value_s1 <= in_value;
			inwin_s1 <= in_win;
			mx_s1    <= mx_n;
			my_s1    <= my_n;
		end
	end

	// Stages 2 and 3: tile column/row and offset within tile
	logic [MC_W-1:0] div_col, div_row;
	logic [RXW-1:0]  div_rx;
	logic [RYW-1:0]  div_ry;

	tmpr_cdiv #(.DIVISOR(TILE_PX_W), .IN_W(MC_W), .REM_W(RXW)) u_div_x (
		.clk      (clk),
		.en       (pipe_en),
		.dividend (mx_s1),
		.quot     (div_col),
		.rem      (div_rx)
	);

	tmpr_cdiv #(.DIVISOR(TILE_PX_H), .IN_W(MC_W), .REM_W(RYW)) u_div_y (
		.clk      (clk),
		.en       (pipe_en),
		.dividend (my_s1),
		.quot     (div_row),
		.rem      (div_ry)
	);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			kind_s2  <= kind_s1;
			slot_s2  <= slot_s1;
			value_s2 <= value_s1;
			inwin_s2 <= inwin_s1;
			kind_s3  <= kind_s2;
			slot_s3  <= slot_s2;
			value_s3 <= value_s2;
			inwin_s3 <= inwin_s2;
		end
	end

	// Stage 4: map cell address and bounds
	logic [16:0]    map_lin;
	logic [11:0]    map_addr_s4;
	logic           outmap_s4, outmap_s5, outmap_s6, outmap_s7;
	logic [RXW-1:0] rx_s4, rx_s5;
	logic [RYW-1:0] ry_s4, ry_s5;

	// row and column are below 256 whenever the cell is inside the map
	assign map_lin = div_row[7:0] * MAPC_C + {9'b0, div_col[7:0]};

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			kind_s4     <= kind_s3;
			slot_s4     <= slot_s3;
			value_s4    <= value_s3;
			inwin_s4    <= inwin_s3;
			map_addr_s4 <= map_lin[11:0];
			outmap_s4   <= ({1'b0, div_col} >= MAPC_LIM) || ({1'b0, div_row} >= MAPR_LIM);
			rx_s4       <= div_rx;
			ry_s4       <= div_ry;
		end
	end

	// Map store, used from stage 4
	logic                       map_en, map_we;
	logic [tmpr_pkg::MAP_DW-1:0] map_rdata;
	assign map_we = (kind_s4 == tmpr_pkg::KIND_MAP);
	assign map_en = pipe_en && v_s4 && (map_we || (kind_s4 == tmpr_pkg::KIND_RENDER));

	tmpr_ram #(.WIDTH(tmpr_pkg::MAP_DW), .DEPTH(tmpr_pkg::MAP_DEPTH)) u_map (
		.clk   (clk),
		.en    (map_en),
		.we    (map_we),
		.addr  (map_we ? slot_s4 : map_addr_s4),
		.wdata (value_s4[7:0]),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			kind_s5   <= kind_s4;
			slot_s5   <= slot_s4;
			value_s5  <= value_s4;
			inwin_s5  <= inwin_s4;
			outmap_s5 <= outmap_s4;
			rx_s5     <= rx_s4;
			ry_s5     <= ry_s4;
		end
	end

	// Stage 5: tile number known; tile pixel and transparent lookups
	logic [21:0] pix_lin;
	logic        empty_n;
	assign pix_lin = map_rdata * TPIX_C + ry_s5 * TW_C + 22'(rx_s5);
	assign empty_n = (map_rdata >= {3'b0, cfg_tile_count_q}) ||
	                 ({1'b0, map_rdata} >= MAXT_C);

	logic                        pix_en, pix_we;
	logic [tmpr_pkg::PIX_DW-1:0] pix_rdata;
	assign pix_we = (kind_s5 == tmpr_pkg::KIND_TILE_PIX);
	assign pix_en = pipe_en && v_s5 && (pix_we || (kind_s5 == tmpr_pkg::KIND_RENDER));

	tmpr_ram #(.WIDTH(tmpr_pkg::PIX_DW), .DEPTH(tmpr_pkg::PIX_DEPTH)) u_pix (
		.clk   (clk),
		.en    (pix_en),
		.we    (pix_we),
		.addr  (pix_we ? slot_s5 : pix_lin[11:0]),
		.wdata (value_s5[3:0]),
		.rdata (pix_rdata)
	);

	logic                        trn_en, trn_we;
	logic [tmpr_pkg::TRN_DW-1:0] trn_rdata;
	assign trn_we = (kind_s5 == tmpr_pkg::KIND_TRANSP);
	assign trn_en = pipe_en && v_s5 && (trn_we || (kind_s5 == tmpr_pkg::KIND_RENDER));

	tmpr_ram #(.WIDTH(tmpr_pkg::TRN_DW), .DEPTH(tmpr_pkg::TRN_DEPTH)) u_trn (
		.clk   (clk),
		.en    (trn_en),
		.we    (trn_we),
		.addr  (trn_we ? slot_s5[3:0] : map_rdata[3:0]),
		.wdata (value_s5),
		.rdata (trn_rdata)
	);

	logic [7:0] tile_s6;
	logic       empty_s6, empty_s7;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			kind_s6   <= kind_s5;
			slot_s6   <= slot_s5;
			value_s6  <= value_s5;
			inwin_s6  <= inwin_s5;
			outmap_s6 <= outmap_s5;
			tile_s6   <= map_rdata;
			empty_s6  <= empty_n;
		end
	end

	// Stage 6: palette lookup
	logic [16:0]                 pal_lin;
	logic                        pal_en, pal_we;
	logic [tmpr_pkg::PAL_DW-1:0] pal_rdata;
	assign pal_lin = tile_s6 * PE_C + {13'b0, pix_rdata};
	assign pal_we  = (kind_s6 == tmpr_pkg::KIND_PALETTE);
	assign pal_en  = pipe_en && v_s6 && (pal_we || (kind_s6 == tmpr_pkg::KIND_RENDER));

	tmpr_ram #(.WIDTH(tmpr_pkg::PAL_DW), .DEPTH(tmpr_pkg::PAL_DEPTH)) u_pal (
		.clk   (clk),
		.en    (pal_en),
		.we    (pal_we),
		.addr  (pal_we ? slot_s6[7:0] : pal_lin[7:0]),
		.wdata (value_s6[15:0]),
		.rdata (pal_rdata)
	);

	logic [16:0] trans_s7;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			kind_s7   <= kind_s6;
			inwin_s7  <= inwin_s6;
			outmap_s7 <= outmap_s6;
			empty_s7  <= empty_s6;
			trans_s7  <= trn_rdata;
		end
	end

	// Stage 7: transparency and background selection
	tmpr_pkg::pix_t res;
	logic           use_bg;
	// a negative transparent color has its sign bit set and never matches
	assign use_bg = outmap_s7 || empty_s7 || ({1'b0, pal_rdata} == trans_s7);

	always_comb begin
		res = '0;
		if ((kind_s7 == tmpr_pkg::KIND_RENDER) && inwin_s7) begin
			if (use_bg) begin
				if (!cfg_background_q[16]) begin
					res.color = cfg_background_q[15:0];
					res.write = 1'b1;
				end
			end else begin
				res.color = pal_rdata;
				res.write = 1'b1;
			end
		end
	end

	tmpr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pipe_en && v_s7),
		.push_data (res),
		.ready     (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTHESIS
	// a stall freezes every stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> ($stable(v_s1) && $stable(v_s4) && $stable(v_s7) && $stable(kind_s7)))
		else $error("pipeline moved during a stall");

	// stores are touched only on an advance
	a_store_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(map_en || pix_en || trn_en || pal_en) |-> s_tready)
		else $error("store accessed while stalled");

	// input stalls only behind a waiting result
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");
`endif

endmodule
